/* design/scfd_pkg.sv */
// Shared types, constants and arithmetic helpers for the stereo cross-feedback delay.
// No dependencies; used by every other file of the block.
package scfd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FEED_W   = 15;
   localparam int SUM_W    = SAMPLE_W + 1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [FEED_W-1:0]   feed_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   // one line slot: the terms waiting for each channel
   typedef struct packed {
      feed_type to_left;
      feed_type to_right;
   } feed_pair_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_type;

   // saturate a sum to the sample range
   function automatic sample_type clip16(input sum_type v);
      sample_type res;
      if (v > SUM_W'(SAMPLE_MAX)) begin
         res = SAMPLE_MAX;
      end else if (v < SUM_W'(SAMPLE_MIN)) begin
         res = SAMPLE_MIN;
      end else begin
         res = v[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // floor((v+1)/4) of the unclipped sum, kept to the stored width
   function automatic feed_type quarter15(input sum_type v);
      logic signed [SUM_W:0] t;
      t = (SUM_W+1)'(v) + (SUM_W+1)'(1);
      return t[FEED_W+1:2];
   endfunction

endpackage

/* design/scfd_if.sv */
// Valid/ready channel interfaces for sample pairs in and results out.
// Depends on scfd_pkg for the sample type.
interface scfd_req_if;
   logic                valid;
   logic                ready;
   scfd_pkg::sample_type left_in;
   scfd_pkg::sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scfd_rsp_if;
   logic                valid;
   logic                ready;
   scfd_pkg::sample_type left_out;
   scfd_pkg::sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* design/scfd_line.sv */
// Feedback delay line: one write port, one registered read port, per-slot valid flags.
// Depends on scfd_pkg for the slot type.
module scfd_line #(
   parameter int DEPTH = 24,
   parameter int AW    = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output scfd_pkg::feed_pair_type rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  scfd_pkg::feed_pair_type wr_data
);
   import scfd_pkg::*;

   feed_pair_type     mem [DEPTH];
   logic [DEPTH-1:0]  slot_vld_ff;
   feed_pair_type     rd_word_ff;
   feed_pair_type     fwd_word_ff;
   logic              rd_vld_ff;
   logic              fwd_ff;

   // store the new terms and mark the slot written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (wr_en) begin
         slot_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read; catch a write to the same slot in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_vld_ff   <= slot_vld_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_word_ff <= wr_data;
      end
   end

   // a slot never written reads as zero
   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_word_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_word_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

/* design/scfd_calc.sv */
// Cross-feedback arithmetic: add delayed terms, saturate outputs, form new quarters.
// Depends on scfd_pkg for types, clip16 and quarter15.
module scfd_calc (
   input  logic                    bypass,
   input  scfd_pkg::stereo_type    samples,
   input  scfd_pkg::feed_pair_type feed,
   output scfd_pkg::stereo_type    result,
   output scfd_pkg::feed_pair_type feed_new
);
   import scfd_pkg::*;

   sum_type sum_l;
   sum_type sum_r;

   // add each channel's sample to the term from the opposite channel
   assign sum_l = SUM_W'(samples.left)  + SUM_W'(feed.to_left);
   assign sum_r = SUM_W'(samples.right) + SUM_W'(feed.to_right);

   // pass samples through untouched while bypassed
   always_comb begin
      if (bypass) begin
         result = samples;
      end else begin
         result.left  = clip16(sum_l);
         result.right = clip16(sum_r);
      end
   end

   // cross the quarters over for the next lap of the line
   assign feed_new.to_left  = quarter15(sum_r);
   assign feed_new.to_right = quarter15(sum_l);

endmodule

/* design/stereo_cross_feedback_delay.sv */
// Stereo cross-feedback delay: each accepted item passes through the input register and
// the result register before its result is presented. Throughput is one item per cycle
// while the output is not stalled; the line's single read and single write port serve one
// pair per cycle, with same-slot write data forwarded to the read.
// Synchronous reset clears bypass, the line position, the pipeline valids and the
// per-slot valid flags, so every slot reads as zero until first written.
module stereo_cross_feedback_delay #(
   parameter int DELAY_PAIRS = 24
) (
   input  logic     clock,
   input  logic     reset,
   scfd_req_if.sink   req_if,
   scfd_rsp_if.source rsp_if,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);
   import scfd_pkg::*;

   localparam int AW = (DELAY_PAIRS > 1) ? $clog2(DELAY_PAIRS) : 1;
   localparam logic [AW-1:0] LAST_POS = AW'(DELAY_PAIRS - 1);

   logic          bypass_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] pos_in;
   logic          s1_vld_ff;
   logic          s1_vld_in;
   stereo_type    s1_samp_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          rsp_vld_ff;
   logic          rsp_vld_in;
   stereo_type    rsp_samp_ff;

   logic          req_fire;
   logic          s1_move;
   logic          wr_en;
   feed_pair_type rd_feed;
   feed_pair_type feed_new;
   stereo_type    calc_res;
   stereo_type    req_samp;

   // handshake
   assign req_fire     = req_if.valid && req_if.ready;
   assign s1_move      = s1_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s1_vld_ff || s1_move;
   assign wr_en        = s1_move && !bypass_ff;

   assign req_samp.left  = req_if.left_in;
   assign req_samp.right = req_if.right_in;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (csr_wr_en) begin
         bypass_ff <= csr_wr_data;
      end
   end

   // advance the line position per processed pair, wrap at the last slot
   always_comb begin
      pos_in = pos_ff;
      if (req_fire && !bypass_ff) begin
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + AW'(1);
      end
   end

   // pipeline valids
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_move) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // input register: hold the item and its slot while the line read completes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_samp_ff <= req_samp;
         s1_addr_ff <= pos_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_samp_ff <= calc_res;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.left_out  = rsp_samp_ff.left;
   assign rsp_if.right_out = rsp_samp_ff.right;

   scfd_line #(
      .DEPTH (DELAY_PAIRS),
      .AW    (AW)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (rd_feed),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (feed_new)
   );

   scfd_calc u_calc (
      .bypass   (bypass_ff),
      .samples  (s1_samp_ff),
      .feed     (rd_feed),
      .result   (calc_res),
      .feed_new (feed_new)
   );

   // position moves only for a processed pair
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && !bypass_ff) |=> $stable(pos_ff))
      else $error("line position moved without a processed item");

   // no line write while bypassed
   a_no_write_bypass: assert property (@(posedge clock) disable iff (reset)
      bypass_ff |-> !wr_en)
      else $error("delay line written during bypass");

   // an item leaving the input register shows up as a result next cycle
   a_move_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_vld_ff)
      else $error("result lost after leaving input register");

   // never overwrite a held item
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_move) |-> !req_fire)
      else $error("item accepted over a stalled item");

endmodule

/* dv/stereo_cross_feedback_delay_tb.sv */
// Self-checking testbench for stereo_cross_feedback_delay: directed extremes, bypass,
// random pairs under four idling mixes and a long output hold-off, checked per field.
// Depends on scfd_pkg, scfd_if and the block itself.
module stereo_cross_feedback_delay_tb;
   import scfd_pkg::*;

   localparam int LINE_DEPTH   = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 6;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   scfd_req_if req_ch ();
   scfd_rsp_if rsp_ch ();

   stereo_cross_feedback_delay #(
      .DELAY_PAIRS(LINE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: the delay line, its slot pointer and the bypass bit
   feed_type echo_to_left [LINE_DEPTH];
   feed_type echo_to_right [LINE_DEPTH];
   int       echo_slot;
   logic     bypass_on;

   stereo_type pending_pairs[$];

   int req_idle_pct;
   int rsp_stall_pct;
   int hold_cycles;
   int cycle_count;
   int pairs_sent;
   int bypass_pairs;
   int results_checked;
   int fail_count;

   // free-running clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // saturate a wide sum to the sample range
   function automatic sample_type saturate(input int v);
      if (v > 32767) begin
         return sample_type'(32767);
      end else if (v < -32768) begin
         return sample_type'(-32768);
      end
      return sample_type'(v);
   endfunction

   // work out one result and advance the line, as the block must
   function automatic stereo_type predict_echo(input sample_type l, input sample_type r);
      stereo_type res;
      int         sum_l;
      int         sum_r;
      if (bypass_on) begin
         res.left  = l;
         res.right = r;
         return res;
      end
      sum_l = int'(l) + int'(echo_to_left[echo_slot]);
      sum_r = int'(r) + int'(echo_to_right[echo_slot]);
      res.left  = saturate(sum_l);
      res.right = saturate(sum_r);
      // store rounded quarters of the unclipped sums, crossed over
      echo_to_left[echo_slot]  = feed_type'((sum_r + 1) >>> 2);
      echo_to_right[echo_slot] = feed_type'((sum_l + 1) >>> 2);
      echo_slot = (echo_slot == LINE_DEPTH - 1) ? 0 : echo_slot + 1;
      return res;
   endfunction

   // predict on every accepted item
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (bypass_on) bypass_pairs++;
         pairs_sent++;
         pending_pairs.push_back(predict_echo(req_ch.left_in, req_ch.right_in));
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      stereo_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pairs.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result left_out %0d right_out %0d", $time,
                     rsp_ch.left_out, rsp_ch.right_out);
         end else begin
            want = pending_pairs.pop_front();
            results_checked++;
            if (rsp_ch.left_out !== want.left) begin
               fail_count++;
               $display("%0t: left_out expected %0d, actual %0d", $time,
                        want.left, rsp_ch.left_out);
            end
            if (rsp_ch.right_out !== want.right) begin
               fail_count++;
               $display("%0t: right_out expected %0d, actual %0d", $time,
                        want.right, rsp_ch.right_out);
            end
         end
      end
   end

   // receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // count cycles and stop a hung run
   always @(posedge clock) cycle_count++;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // offer one pair after a random gap and hold it until accepted
   task automatic send_pair(input int l, input int r);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < req_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.left_in  = sample_type'(l);
      req_ch.right_in = sample_type'(r);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic drain;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the bypass register while idle
   task automatic write_bypass(input logic v);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(posedge clock);
      bypass_on = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // spread samples over the full range, the rails and small values
   function automatic int rand_sample();
      case ($urandom_range(3))
         0: return int'($urandom_range(65535)) - 32768;
         1: return 32767 - int'($urandom_range(3000));
         2: return -32768 + int'($urandom_range(3000));
         default: return int'($urandom_range(40)) - 20;
      endcase
   endfunction

   // extremes, rounding of small sums, then wrap round the line into clipping
   task automatic test_directed;
      int i;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_pair(32767, 32767);
      send_pair(-32768, -32768);
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      send_pair(0, 0);
      send_pair(-1, -2);
      send_pair(2, 3);
      send_pair(1, -3);
      send_pair(-4, -5);
      send_pair(16384, -16384);
      send_pair(21845, -21846);
      for (i = 11; i < LINE_DEPTH; i++) begin
         if (i % 2) send_pair(16'sh5555, -21846);
         else       send_pair(-21846, 16'sh5555);
      end
      // these read the first slots back and saturate both ways
      send_pair(32767, 32767);
      send_pair(-32768, -32768);
      drain();
   endtask

   // pass-through with the line frozen, then resume where it stopped
   task automatic test_bypass;
      int i;
      write_bypass(1'b1);
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      for (i = 0; i < 6; i++) send_pair(rand_sample(), rand_sample());
      drain();
      write_bypass(1'b0);
      for (i = 0; i < 30; i++) send_pair(rand_sample(), rand_sample());
      drain();
   endtask

   // random pairs under each idling mix, with a short bypass burst in each
   task automatic test_random;
      int idle_mix [4];
      int stall_mix [4];
      int ph;
      int i;
      idle_mix  = '{0, 50, 0, 27};
      stall_mix = '{0, 0, 50, 27};
      for (ph = 0; ph < 4; ph++) begin
         req_idle_pct  = idle_mix[ph];
         rsp_stall_pct = stall_mix[ph];
         write_bypass(1'b0);
         for (i = 0; i < 95; i++) send_pair(rand_sample(), rand_sample());
         drain();
         write_bypass(1'b1);
         for (i = 0; i < 8; i++) send_pair(rand_sample(), rand_sample());
         drain();
      end
      write_bypass(1'b0);
   endtask

   // hold the output off so the block fills and stalls, then pause to empty and rerun with random gaps and stalls
   task automatic test_backpressure;
      int i;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_cycles   = 150;
      for (i = 0; i < 50; i++) send_pair(rand_sample(), rand_sample());
      drain();
      req_idle_pct  = 27;
      rsp_stall_pct = 27;
      for (i = 0; i < 40; i++) send_pair(rand_sample(), rand_sample());
      drain();
   endtask

   initial begin
      int i;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.left_in  = '0;
      req_ch.right_in = '0;
      rsp_ch.ready    = 1'b0;
      req_idle_pct    = 0;
      rsp_stall_pct   = 0;
      hold_cycles     = 0;
      cycle_count     = 0;
      pairs_sent      = 0;
      bypass_pairs    = 0;
      results_checked = 0;
      fail_count      = 0;
      bypass_on       = 1'b0;
      echo_slot       = 0;
      for (i = 0; i < LINE_DEPTH; i++) begin
         echo_to_left[i]  = '0;
         echo_to_right[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_bypass();
      test_random();
      test_backpressure();

      if (pending_pairs.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected results never arrived", $time, pending_pairs.size());
      end
      $display("Sent %0d pairs (%0d in bypass) across four idling mixes and a long hold-off;",
               pairs_sent, bypass_pairs);
      $display("checked %0d results, %0d mismatches.", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
